@@ hdl/adc_i2c_register_slave_core_defines.svh @@
// ----------------------------------------------------------------------------
// ADC I2C register slave assertion macros
// Shared concurrent assertion forms for the checker of the register slave.
// ----------------------------------------------------------------------------
`ifndef ADC_I2C_REGISTER_SLAVE_CORE_DEFINES_SVH
`define ADC_I2C_REGISTER_SLAVE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADCREG_ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("adcreg: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ADCREG_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("adcreg: next-cycle check failed");

`endif

@@ hdl/adcreg_pkg.sv @@
// ----------------------------------------------------------------------------
// ADC I2C register slave package
// Bus event codes, register pointer values and config constants.
// ----------------------------------------------------------------------------
package adcreg_pkg;

    typedef enum logic [1:0] {
        MODE_EVENT = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    localparam logic [7:0]  PTR_CONVERSION  = 8'h00;
    localparam logic [7:0]  PTR_CONFIG      = 8'h01;
    localparam logic [15:0] CONFIG_RESET    = 16'h8583;
    localparam logic [15:0] CONFIG_READ_SET = 16'h8000;

    localparam logic [7:0]  PHASE_POINTER   = 8'd0;
    localparam logic [7:0]  PHASE_CFG_HIGH  = 8'd1;
    localparam logic [7:0]  PHASE_CFG_LOW   = 8'd2;

    typedef logic signed [15:0] sample_t;

endpackage

@@ hdl/adc_i2c_register_slave_core.sv @@
// ----------------------------------------------------------------------------
// ADC I2C register slave core
// Register side of a four-channel ADC acting as an I2C target.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_ channel is one bus event: a start or stop with an
// address, a byte written by the controller, or a request for a read byte.
// Every request also carries the current codes of all four channels.
// Each request produces exactly one result on the m_ channel with the read
// byte and the acknowledge bit.
// A request is first captured in an input register; once the result
// register is free or being taken, the register update and the result are
// computed and loaded into the result register, which raises m_valid.
// Throughput is one request per cycle while m_ready stays high; the pointer,
// counters and config word are updated as each result is loaded.
// Synchronous reset clears both stages, the pointer and the counters, and
// loads the config word with 0x8583.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; s_ready then drops until m_ready
// returns.
// ----------------------------------------------------------------------------
module adc_i2c_register_slave_core #(
    parameter logic [6:0] DEVICE_ADDRESS = 7'd72
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic                s_start_flag,
    input  logic [6:0]          s_bus_address,
    input  logic [7:0]          s_write_byte,
    input  adcreg_pkg::sample_t s_sample_ch0,
    input  adcreg_pkg::sample_t s_sample_ch1,
    input  adcreg_pkg::sample_t s_sample_ch2,
    input  adcreg_pkg::sample_t s_sample_ch3,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_read_byte,
    output logic                m_ack
);
    import adcreg_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [1:0]  mode_reg;
    logic        start_flag_reg;
    logic [6:0]  bus_address_reg;
    logic [7:0]  write_byte_reg;
    sample_t     sample_reg [4];

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  read_byte_reg, read_byte_next;
    logic        ack_reg, ack_next;

    logic [7:0]  pointer_reg, pointer_next;
    logic [7:0]  write_phase_reg, write_phase_next;
    logic [7:0]  read_index_reg, read_index_next;
    logic [15:0] config_word_reg, config_word_next;

    logic        accept;
    logic        advance;
    logic [2:0]  mux;
    logic [15:0] selected;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign m_valid     = out_valid_reg;
    assign m_read_byte = read_byte_reg;
    assign m_ack       = ack_reg;

    assign mux = config_word_reg[14:12];

    always_comb begin
        selected = 16'h0000;
        if (pointer_reg == PTR_CONVERSION) begin
            if (mux[2]) begin
                selected = 16'(sample_reg[mux[1:0]]);
            end
        end else if (pointer_reg == PTR_CONFIG) begin
            selected = config_word_reg | CONFIG_READ_SET;
        end
    end

    always_comb begin
        in_valid_next    = in_valid_reg;
        out_valid_next   = out_valid_reg;
        read_byte_next   = read_byte_reg;
        ack_next         = ack_reg;
        pointer_next     = pointer_reg;
        write_phase_next = write_phase_reg;
        read_index_next  = read_index_reg;
        config_word_next = config_word_reg;

        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        if (advance) begin
            out_valid_next = 1'b1;
            read_byte_next = 8'h00;
            ack_next       = 1'b0;
            case (mode_t'(mode_reg))
                MODE_EVENT: begin
                    if (start_flag_reg) begin
                        write_phase_next = 8'h00;
                        read_index_next  = 8'h00;
                    end
                    ack_next = (bus_address_reg == DEVICE_ADDRESS);
                end
                MODE_WRITE: begin
                    if (write_phase_reg == PHASE_POINTER) begin
                        pointer_next    = write_byte_reg;
                        read_index_next = 8'h00;
                    end else if (write_phase_reg == PHASE_CFG_HIGH &&
                                 pointer_reg == PTR_CONFIG) begin
                        config_word_next = {write_byte_reg, config_word_reg[7:0]};
                    end else if (write_phase_reg == PHASE_CFG_LOW &&
                                 pointer_reg == PTR_CONFIG) begin
                        config_word_next = {config_word_reg[15:8], write_byte_reg};
                    end
                    write_phase_next = write_phase_reg + 8'd1;
                    ack_next         = 1'b1;
                end
                MODE_READ: begin
                    if (read_index_reg == 8'h00) begin
                        read_byte_next = selected[15:8];
                    end else begin
                        read_byte_next = selected[7:0];
                    end
                    read_index_next = read_index_reg + 8'd1;
                    ack_next        = 1'b1;
                end
                default: begin
                    ack_next = 1'b0;
                end
            endcase
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pointer_reg     <= PTR_CONVERSION;
            write_phase_reg <= 8'h00;
            read_index_reg  <= 8'h00;
            config_word_reg <= CONFIG_RESET;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            pointer_reg     <= pointer_next;
            write_phase_reg <= write_phase_next;
            read_index_reg  <= read_index_next;
            config_word_reg <= config_word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg        <= s_mode;
            start_flag_reg  <= s_start_flag;
            bus_address_reg <= s_bus_address;
            write_byte_reg  <= s_write_byte;
            sample_reg[0]   <= s_sample_ch0;
            sample_reg[1]   <= s_sample_ch1;
            sample_reg[2]   <= s_sample_ch2;
            sample_reg[3]   <= s_sample_ch3;
        end
        read_byte_reg <= read_byte_next;
        ack_reg       <= ack_next;
    end

endmodule

@@ hdl/adcreg_checker.sv @@
// ----------------------------------------------------------------------------
// ADC I2C register slave checker
// Port-level checks of reset, stall and occupancy behavior.
// ----------------------------------------------------------------------------
`include "adc_i2c_register_slave_core_defines.svh"

module adcreg_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_byte,
    input logic       m_ack
);

    logic [1:0] count_reg, count_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        count_next = count_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    `ADCREG_ASSERT_NEXT(a_reset_clears, aclk, 1'b0, !aresetn, !m_valid)
    `ADCREG_ASSERT_NEXT(a_stall_holds, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_read_byte) && $stable(m_ack))
    `ADCREG_ASSERT_SAME(a_full_blocks, aclk, !aresetn, count_reg == 2'd2 && !m_ready, !s_ready)
    `ADCREG_ASSERT_SAME(a_result_owed, aclk, !aresetn, m_valid, count_reg != 2'd0 && count_reg != 2'd3)

endmodule

bind adc_i2c_register_slave_core adcreg_checker u_adcreg_checker (.*);
